FILE: design/ssb_pkg.sv
// ----------------------------------------------------------------------------
// Strided slice bounds package
// Shared widths, register indexes, the item record that flows down the
// pipeline and the index clamping function.
// ----------------------------------------------------------------------------
`default_nettype none

package ssb_pkg;

	localparam int IDX_W      = 32;	// signed index and stride width
	localparam int SIZE_W     = 31;	// axis size width
	localparam int LEN_W      = 31;	// output length width
	localparam int MASK_W     = 4;	// mask register width
	localparam int AXIS_W     = 2;	// axis number width
	localparam int CFG_IDX_W  = 2;	// configuration index width
	localparam int DIV_BITS   = LEN_W;	// one divider cell per quotient bit

	localparam logic [CFG_IDX_W-1:0] REG_BEGIN_MASK = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_END_MASK   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DROP_MASK  = 2'd2;

	// One request as it moves through the divider chain.
	typedef struct packed {
		logic signed [IDX_W-1:0] start_index;
		logic signed [IDX_W-1:0] stop_index;
		logic                    nonempty;
		logic                    status;
		logic                    axis_kept;
		logic [IDX_W-1:0]        divisor;
		logic [IDX_W-1:0]        rem;
		logic [DIV_BITS-1:0]     dvd;
		logic [DIV_BITS-1:0]     quo;
	} ssb_item_t;

	// Clamps a requested index to the axis and wraps negative indices.
	function automatic logic signed [IDX_W:0] clamp_idx(
		input logic signed [IDX_W:0] idx,
		input logic signed [IDX_W:0] size,
		input logic                  fwd
	);
		logic signed [IDX_W:0] res;
		if (fwd) begin
			if (idx >= size) begin
				res = size;
			end else if (idx < -size) begin
				res = '0;
			end else if (idx < 0) begin
				res = idx + size;
			end else begin
				res = idx;
			end
		end else begin
			if (idx < -size) begin
				res = '1;
			end else if (idx >= size) begin
				res = size - 33'sd1;
			end else if (idx < 0) begin
				res = idx + size;
			end else begin
				res = idx;
			end
		end
		return res;
	endfunction

endpackage

`default_nettype wire

FILE: design/strided_slice_bounds_top.sv
// ----------------------------------------------------------------------------
// Strided slice bounds top level
// Normalizes the begin, end and stride of one tensor axis per request and
// returns start, stop, element count, the keep flag and a status.
// ----------------------------------------------------------------------------
// Usage: each input request carries an axis number, its size and the
// requested begin, end and step. The three mask registers are written over
// the configuration channel (index 0 begin default, 1 end default, 2 drop);
// a write to any other index is ignored. Writes are taken at every cycle and
// should only be issued while no request is in flight.
// The path holds 34 register stages: two normalization stages, one divider
// cell per quotient bit (31 cells) and the output register. One request is
// accepted per cycle while the first stage is free; the divider chain moves
// one request per cell per cycle whenever the next stage can take it.
// Every stage holds its own valid flag and moves independently, so a stall
// at the output only fills the stages behind it; requests keep entering
// until the whole chain is occupied. Reset clears the masks and all valid
// flags; no data is lost or duplicated across a stall.
// ----------------------------------------------------------------------------
`default_nettype none

module strided_slice_bounds_top import ssb_pkg::*; #(
	parameter int MAX_AXES = 4
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    cfg_valid,
	output logic                         cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [MASK_W-1:0]       cfg_data,
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire logic [AXIS_W-1:0]       axis,
	input  wire logic [SIZE_W-1:0]       axis_size,
	input  wire logic signed [IDX_W-1:0] begin_request,
	input  wire logic signed [IDX_W-1:0] end_request,
	input  wire logic signed [IDX_W-1:0] step,
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output logic signed [IDX_W-1:0]      start_index,
	output logic signed [IDX_W-1:0]      stop_index,
	output logic [LEN_W-1:0]             out_length,
	output logic                         axis_kept,
	output logic                         status
);

	// Handshake and payload between the front end, the cells and the output.
	// Position 0 is the front end output; position DIV_BITS feeds the output.
	logic      chain_valid [DIV_BITS+1];
	logic      chain_ready [DIV_BITS+1];
	ssb_item_t chain_item  [DIV_BITS+1];

	// The front end clamps the bounds and forms span minus one, so that the
	// ceiling division becomes a floor division followed by an increment.
	ssb_front #(
		.MAX_AXES(MAX_AXES)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.axis         (axis),
		.axis_size    (axis_size),
		.begin_request(begin_request),
		.end_request  (end_request),
		.step         (step),
		.down_valid   (chain_valid[0]),
		.down_item    (chain_item[0]),
		.down_ready   (chain_ready[0])
	);

	// Each cell resolves one quotient bit, most significant first.
	for (genvar i = 0; i < DIV_BITS; i++) begin : g_cell
		ssb_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.up_valid  (chain_valid[i]),
			.up_ready  (chain_ready[i]),
			.up_item   (chain_item[i]),
			.down_valid(chain_valid[i+1]),
			.down_item (chain_item[i+1]),
			.down_ready(chain_ready[i+1])
		);
	end

	// The output stage finishes the length and holds the result.
	ssb_out u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.up_valid   (chain_valid[DIV_BITS]),
		.up_ready   (chain_ready[DIV_BITS]),
		.up_item    (chain_item[DIV_BITS]),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.start_index(start_index),
		.stop_index (stop_index),
		.out_length (out_length),
		.axis_kept  (axis_kept),
		.status     (status)
	);

endmodule

`default_nettype wire

FILE: design/ssb_front.sv
// ----------------------------------------------------------------------------
// Strided slice bounds front end
// Holds the mask registers, normalizes start and stop, and prepares the
// dividend and divisor for the divider chain. Two pipeline stages.
// ----------------------------------------------------------------------------
`default_nettype none

module ssb_front import ssb_pkg::*; #(
	parameter int MAX_AXES = 4
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    cfg_valid,
	output logic                         cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [MASK_W-1:0]       cfg_data,
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire logic [AXIS_W-1:0]       axis,
	input  wire logic [SIZE_W-1:0]       axis_size,
	input  wire logic signed [IDX_W-1:0] begin_request,
	input  wire logic signed [IDX_W-1:0] end_request,
	input  wire logic signed [IDX_W-1:0] step,
	output logic                         down_valid,
	output ssb_item_t                    down_item,
	input  wire logic                    down_ready
);

	localparam int STORE_W = (MAX_AXES < MASK_W) ? MAX_AXES : MASK_W;

	logic [STORE_W-1:0] begin_mask_q, end_mask_q, drop_mask_q;
	logic [MASK_W-1:0]  begin_eff, end_eff, drop_eff;

	logic                    valid_s1, ready_s1;
	logic signed [IDX_W-1:0] start_s1, stop_s1, step_s1;
	logic                    fwd_s1, zero_s1, kept_s1;

	logic                    valid_s2, ready_s2;
	ssb_item_t               item_s2;

	logic signed [IDX_W:0]   size_x, start_c, stop_c, nm1_c;
	logic                    fwd_c, zero_c;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			begin_mask_q <= '0;
			end_mask_q   <= '0;
			drop_mask_q  <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_BEGIN_MASK: begin_mask_q <= cfg_data[STORE_W-1:0];
				REG_END_MASK:   end_mask_q   <= cfg_data[STORE_W-1:0];
				REG_DROP_MASK:  drop_mask_q  <= cfg_data[STORE_W-1:0];
				default: ;
			endcase
		end
	end

	// Axes beyond the supported count read their mask bits as zero.
	for (genvar i = 0; i < MASK_W; i++) begin : g_mask
		if (i < STORE_W) begin : g_used
			assign begin_eff[i] = begin_mask_q[i];
			assign end_eff[i]   = end_mask_q[i];
			assign drop_eff[i]  = drop_mask_q[i];
		end else begin : g_zero
			assign begin_eff[i] = 1'b0;
			assign end_eff[i]   = 1'b0;
			assign drop_eff[i]  = 1'b0;
		end
	end

	// Stage 1: clamp and wrap both bounds.
	always_comb begin
		size_x = $signed({2'b00, axis_size});
		fwd_c  = !step[IDX_W-1];
		zero_c = (step == '0);
		if (zero_c) begin
			start_c = '0;
			stop_c  = '0;
		end else begin
			if (begin_eff[axis]) begin
				start_c = fwd_c ? '0 : size_x - 33'sd1;
			end else begin
				start_c = clamp_idx($signed({begin_request[IDX_W-1], begin_request}), size_x,
					fwd_c);
			end
			if (end_eff[axis]) begin
				stop_c = fwd_c ? size_x : '1;
			end else begin
				stop_c = clamp_idx($signed({end_request[IDX_W-1], end_request}), size_x, fwd_c);
			end
		end
	end

	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_ready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && ready_s1) begin
			start_s1 <= start_c[IDX_W-1:0];
			stop_s1  <= stop_c[IDX_W-1:0];
			step_s1  <= step;
			fwd_s1   <= fwd_c;
			zero_s1  <= zero_c;
			kept_s1  <= !drop_eff[axis];
		end
	end

	// Stage 2: span minus one, so the ceiling becomes floor plus one.
	always_comb begin
		if (fwd_s1) begin
			nm1_c = $signed({stop_s1[IDX_W-1], stop_s1}) + $signed(~{start_s1[IDX_W-1], start_s1});
		end else begin
			nm1_c = $signed({start_s1[IDX_W-1], start_s1}) + $signed(~{stop_s1[IDX_W-1], stop_s1});
		end
	end

	assign ready_s2 = !valid_s2 || down_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && ready_s2) begin
			item_s2.start_index <= start_s1;
			item_s2.stop_index  <= stop_s1;
			item_s2.nonempty    <= !zero_s1 && !nm1_c[IDX_W];
			item_s2.status      <= zero_s1;
			item_s2.axis_kept   <= kept_s1;
			item_s2.divisor     <= fwd_s1 ? step_s1 : -step_s1;
			item_s2.rem         <= '0;
			item_s2.dvd         <= nm1_c[DIV_BITS-1:0];
			item_s2.quo         <= '0;
		end
	end

	assign down_valid = valid_s2;
	assign down_item  = item_s2;

endmodule

`default_nettype wire

FILE: design/ssb_cell.sv
// ----------------------------------------------------------------------------
// Strided slice bounds divider cell
// One restoring division step: brings in the next dividend bit, subtracts
// the divisor when it fits and shifts one quotient bit in.
// ----------------------------------------------------------------------------
`default_nettype none

module ssb_cell import ssb_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      up_valid,
	output logic           up_ready,
	input  wire ssb_item_t up_item,
	output logic           down_valid,
	output ssb_item_t      down_item,
	input  wire logic      down_ready
);

	logic            valid_q;
	ssb_item_t       item_q, next_item;
	logic [IDX_W:0]  trial, diff;

	always_comb begin
		trial     = {up_item.rem, up_item.dvd[DIV_BITS-1]};
		diff      = trial - {1'b0, up_item.divisor};
		next_item = up_item;
		next_item.rem = diff[IDX_W] ? trial[IDX_W-1:0] : diff[IDX_W-1:0];
		next_item.dvd = {up_item.dvd[DIV_BITS-2:0], 1'b0};
		next_item.quo = {up_item.quo[DIV_BITS-2:0], !diff[IDX_W]};
	end

	assign up_ready = !valid_q || down_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && up_ready) begin
			item_q <= next_item;
		end
	end

	assign down_valid = valid_q;
	assign down_item  = item_q;

endmodule

`default_nettype wire

FILE: design/ssb_out.sv
// ----------------------------------------------------------------------------
// Strided slice bounds output stage
// Turns the floor quotient into the output length and holds the result
// until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module ssb_out import ssb_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                up_valid,
	output logic                     up_ready,
	input  wire ssb_item_t           up_item,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic signed [IDX_W-1:0]  start_index,
	output logic signed [IDX_W-1:0]  stop_index,
	output logic [LEN_W-1:0]         out_length,
	output logic                     axis_kept,
	output logic                     status
);

	logic                    valid_q;
	logic signed [IDX_W-1:0] start_q, stop_q;
	logic [LEN_W-1:0]        length_q;
	logic                    kept_q, status_q;

	assign up_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && up_ready) begin
			start_q  <= up_item.start_index;
			stop_q   <= up_item.stop_index;
			length_q <= up_item.nonempty ? up_item.quo + LEN_W'(1) : '0;
			kept_q   <= up_item.axis_kept;
			status_q <= up_item.status;
		end
	end

	assign out_valid   = valid_q;
	assign start_index = start_q;
	assign stop_index  = stop_q;
	assign out_length  = length_q;
	assign axis_kept   = kept_q;
	assign status      = status_q;

endmodule

`default_nettype wire
